FILE: hw/rtl/coordinate_key_table_get_or_insert_macros.svh
// Assertion macros shared by the coordinate key table RTL
`ifndef COORDINATE_KEY_TABLE_GET_OR_INSERT_MACROS_SVH
`define COORDINATE_KEY_TABLE_GET_OR_INSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CKT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ckt_pkg.sv
// Types, constants and controller/datapath interface for the coordinate key table
package ckt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int SLOT_W            = 6;
    localparam int COORD_W           = 16;
    localparam int KEY_W             = 2 * COORD_W;

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_START = 2'd2,
        CMD_NEXT  = 2'd3
    } ckt_op_t;

    typedef struct packed {
        ckt_op_t                    command;
        logic signed [COORD_W-1:0]  key_x;
        logic signed [COORD_W-1:0]  key_y;
    } ckt_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]          slot;
        logic                       was_new;
        logic                       table_full;
        logic                       entry_valid;
        logic signed [COORD_W-1:0]  entry_x;
        logic signed [COORD_W-1:0]  entry_y;
    } ckt_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;   // latch the incoming key
        logic scan_clr;   // rewind the scan pointer
        logic scan_step;  // issue the next scan read, if any remain
        logic rd_cursor;  // read the entry under the iterator cursor
        logic insert;     // miss: append key or flag full, and respond
        logic fill_clr;   // empty the table
        logic cur_clr;    // rewind the iterator
        logic rsp_hit;    // respond with the matching slot
        logic rsp_next;   // respond with the entry just read
        logic rsp_empty;  // respond with an all-zero word
    } ckt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;        // compare stage holds a match
        logic scan_end;   // nothing left to read and nothing in compare
        logic cur_ok;     // cursor is below the fill count
    } ckt_stat_t;

endpackage

FILE: hw/rtl/coordinate_key_table_get_or_insert.sv
// Get-or-insert: a get scans the stored keys in slot order, one key compare per cycle.
// A hit answers with its slot; a miss appends the key at the fill count, or flags full.
// Clear and iterator start answer with an all-zero word; next returns the cursor entry, or zeros past the end.
// One command at a time: busy is high while a get scans or a next reads; done is never held.
// Reset empties the table and rewinds the iterator; the key store itself is not cleared.
module coordinate_key_table_get_or_insert
    import ckt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ckt_req_t request,
    output logic     busy,
    output logic     done,
    output ckt_rsp_t result
);

    ckt_cmd_t  cmd;
    ckt_stat_t stat;

    ckt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (request.command),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ckt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

FILE: hw/rtl/ckt_ctrl.sv
// Command sequencer for the coordinate key table
`include "coordinate_key_table_get_or_insert_macros.svh"

module ckt_ctrl
    import ckt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ckt_op_t   op,
    input  ckt_stat_t stat,
    output ckt_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_NEXT = 3'b100
    } ckt_state_t;

    ckt_state_t state_reg;
    ckt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    unique case (op)
                        CMD_GET:
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            cmd.fill_clr  = 1'b1;
                            cmd.rsp_empty = 1'b1;
                        end
                        CMD_START:
                        begin
                            cmd.cur_clr   = 1'b1;
                            cmd.rsp_empty = 1'b1;
                        end
                        CMD_NEXT:
                        begin
                            if (stat.cur_ok)
                            begin
                                cmd.rd_cursor = 1'b1;
                                state_next    = S_NEXT;
                            end
                            else
                            begin
                                cmd.rsp_empty = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.rsp_empty = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit)
                begin
                    cmd.rsp_hit = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.scan_end)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NEXT:
            begin
                cmd.rsp_next = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `CKT_ASSERT_NEXT(a_get_enters_scan, start && !busy && op == CMD_GET, state_reg == S_SCAN, "get did not start a scan")
    `CKT_ASSERT_NEXT(a_next_one_cycle, state_reg == S_NEXT, state_reg == S_IDLE, "iterator read overran")
    `CKT_ASSERT_NOW(a_one_response, 1'b1, $onehot0({cmd.rsp_hit, cmd.insert, cmd.rsp_next, cmd.rsp_empty}), "two responses in one cycle")

endmodule

FILE: hw/rtl/ckt_dp.sv
// Key store, scan pipeline, counters and result register for the coordinate key table
`include "coordinate_key_table_get_or_insert_macros.svh"

module ckt_dp
    import ckt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ckt_req_t  request,
    input  ckt_cmd_t  cmd,
    output ckt_stat_t stat,
    output logic      done,
    output ckt_rsp_t  result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(TABLE_ENTRIES);

    logic [KEY_W-1:0] mem [TABLE_ENTRIES];

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] rd_data_reg;
    logic [CNT_W-1:0] fill_reg,     fill_next;
    logic [CNT_W-1:0] cursor_reg,   cursor_next;
    logic [CNT_W-1:0] scan_reg,     scan_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             done_reg,     done_next;
    ckt_rsp_t         result_reg,   result_next;

    logic             scan_more;
    logic             scan_rd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             has_room;
    logic             wr_en;

    assign scan_more = (scan_reg < fill_reg);
    assign scan_rd   = cmd.scan_step && scan_more;
    assign rd_en     = scan_rd || cmd.rd_cursor;
    assign rd_addr   = cmd.rd_cursor ? cursor_reg[IDX_W-1:0] : scan_reg[IDX_W-1:0];
    assign has_room  = (fill_reg < CAPACITY);
    assign wr_en     = cmd.insert && has_room;

    // key store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[IDX_W-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg <= {request.key_y, request.key_x};
        end
        if (scan_rd)
        begin
            cmp_idx_reg <= scan_reg[IDX_W-1:0];
        end
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        cursor_next    = cursor_reg;
        scan_next      = scan_reg;
        cmp_valid_next = scan_rd;
        if (cmd.fill_clr)
        begin
            fill_next = '0;
        end
        else if (wr_en)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.cur_clr)
        begin
            cursor_next = '0;
        end
        else if (cmd.rsp_next)
        begin
            cursor_next = cursor_reg + CNT_W'(1);
        end
        if (cmd.scan_clr)
        begin
            scan_next      = '0;
            cmp_valid_next = 1'b0;
        end
        else if (scan_rd)
        begin
            scan_next = scan_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        result_next = '0;
        done_next   = cmd.rsp_hit || cmd.insert || cmd.rsp_next || cmd.rsp_empty;
        if (cmd.rsp_hit)
        begin
            result_next.slot = SLOT_W'(cmp_idx_reg);
        end
        else if (cmd.insert)
        begin
            if (has_room)
            begin
                result_next.slot    = SLOT_W'(fill_reg);
                result_next.was_new = 1'b1;
            end
            else
            begin
                result_next.table_full = 1'b1;
            end
        end
        else if (cmd.rsp_next)
        begin
            // cursor still points at this entry; it steps with this response
            result_next.slot        = SLOT_W'(cursor_reg);
            result_next.entry_valid = 1'b1;
            result_next.entry_x     = rd_data_reg[COORD_W-1:0];
            result_next.entry_y     = rd_data_reg[KEY_W-1:COORD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            cursor_reg    <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            cursor_reg    <= cursor_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    assign stat.hit      = cmp_valid_reg && (rd_data_reg == key_reg);
    assign stat.scan_end = !cmp_valid_reg && !scan_more;
    assign stat.cur_ok   = (cursor_reg < fill_reg);

    assign done   = done_reg;
    assign result = result_reg;

    `CKT_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CAPACITY, "fill count beyond capacity")
    `CKT_ASSERT_NEXT(a_insert_grows, wr_en && !cmd.fill_clr, fill_reg == $past(fill_reg) + CNT_W'(1), "insert did not grow the table")
    `CKT_ASSERT_NOW(a_flags_exclusive, done_reg, $onehot0({result_reg.was_new, result_reg.table_full, result_reg.entry_valid}), "conflicting result flags")

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the coordinate key table get-or-insert block
`timescale 1ns / 100ps

module tb
    import ckt_pkg::*;
();

    localparam int ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int WORD_COUNT = 1750;
    localparam int POOL_SIZE  = 12;

    // Tracks table contents and iterator, and queues the answer each command should get
    class key_table_tracker;
        logic [KEY_W-1:0] keys [ENTRIES];
        int unsigned      fill;
        int unsigned      cursor;
        ckt_rsp_t         awaited [$];
        int unsigned      mismatches;

        function new();
            fill       = 0;
            cursor     = 0;
            mismatches = 0;
        endfunction

        function void note_command(ckt_req_t req);
            ckt_rsp_t         rsp;
            logic [KEY_W-1:0] key;
            bit               hit;
            rsp = '0;
            key = {req.key_y, req.key_x};
            hit = 1'b0;
            case (req.command)
                CMD_GET:
                begin
                    for (int i = 0; i < fill && !hit; i++)
                    begin
                        if (keys[i] == key)
                        begin
                            hit      = 1'b1;
                            rsp.slot = SLOT_W'(i);
                        end
                    end
                    if (!hit)
                    begin
                        if (fill < ENTRIES)
                        begin
                            keys[fill]  = key;
                            rsp.slot    = SLOT_W'(fill);
                            rsp.was_new = 1'b1;
                            fill++;
                        end
                        else
                            rsp.table_full = 1'b1;
                    end
                end
                CMD_CLEAR:
                    fill = 0;   // cursor deliberately left where it is
                CMD_START:
                    cursor = 0;
                CMD_NEXT:
                begin
                    if (cursor < fill)
                    begin
                        rsp.slot        = SLOT_W'(cursor);
                        rsp.entry_valid = 1'b1;
                        rsp.entry_x     = keys[cursor][COORD_W-1:0];
                        rsp.entry_y     = keys[cursor][KEY_W-1:COORD_W];
                        cursor++;
                    end
                end
            endcase
            awaited.push_back(rsp);
        endfunction

        function void field_check(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(ckt_rsp_t got);
            ckt_rsp_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, got %p", $time, got);
                return;
            end
            want = awaited.pop_front();
            field_check("slot",        32'(want.slot),        32'(got.slot));
            field_check("was_new",     32'(want.was_new),     32'(got.was_new));
            field_check("table_full",  32'(want.table_full),  32'(got.table_full));
            field_check("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
            field_check("entry_x",     32'(want.entry_x),     32'(got.entry_x));
            field_check("entry_y",     32'(want.entry_y),     32'(got.entry_y));
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    ckt_req_t request;
    logic     busy;
    logic     done;
    ckt_rsp_t result;

    key_table_tracker tracker = new();
    int unsigned      words_sent;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    coordinate_key_table_get_or_insert dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #1 clk = ~clk;

    // values seen here are those before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                tracker.note_command(request);
            if (done)
                tracker.check_result(result);
        end
    end

    initial
    begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function int unsigned sender_idle_pct();
        if (words_sent < WORD_COUNT / 3)
            return 18;
        else if (words_sent < 2 * WORD_COUNT / 3)
            return 88;
        return 0;
    endfunction

    // one word: hold it until taken, then maybe idle a while with junk on the bus
    task send_word(ckt_op_t op, logic [KEY_W-1:0] key);
        ckt_req_t r;
        int unsigned pct;
        r.command = op;
        r.key_x   = key[COORD_W-1:0];
        r.key_y   = key[KEY_W-1:COORD_W];
        request <= r;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
        pct = sender_idle_pct();
        while ($urandom_range(99) < pct)
        begin
            start   <= 1'b0;
            request <= ckt_req_t'({$urandom, $urandom});
            @(posedge clk);
        end
    endtask

    task send_get(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        send_word(CMD_GET, {y, x});
    endtask

    function logic [KEY_W-1:0] pick_key(int unsigned pool_pct);
        if ($urandom_range(99) < pool_pct)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return KEY_W'($urandom);
    endfunction

    task refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            case ($urandom_range(3))
                0: key_pool[i] = {16'h8000, 16'h7fff};
                1: key_pool[i] = {16'($urandom_range(3)), 16'hffff};
                default: key_pool[i] = KEY_W'($urandom);
            endcase
        end
    endtask

    task fill_run();
        int unsigned n;
        int unsigned pool_pct;
        refresh_pool();
        if ($urandom_range(1))
            send_word(CMD_CLEAR, pick_key(0));
        if ($urandom_range(4) == 0)
        begin
            // long run that should overflow the table
            n        = $urandom_range(ENTRIES, ENTRIES + 8);
            pool_pct = 10;
        end
        else
        begin
            n        = $urandom_range(1, 20);
            pool_pct = 50;
        end
        repeat (n)
            send_word(CMD_GET, pick_key(pool_pct));
    endtask

    task iterate_run();
        if ($urandom_range(9) != 0)
            send_word(CMD_START, pick_key(0));
        repeat ($urandom_range(0, 70))
        begin
            if ($urandom_range(15) == 0)
                send_word(CMD_GET, pick_key(50));
            else
                send_word(CMD_NEXT, pick_key(0));
        end
    endtask

    task noise_run();
        repeat ($urandom_range(1, 8))
            send_word(ckt_op_t'($urandom_range(3)), pick_key(30));
    endtask

    initial
    begin
        int unsigned drain;
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        words_sent = 0;
        refresh_pool();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, hits at first and last slot, readout past the end,
        // clear in mid-iteration
        send_word(CMD_CLEAR, '0);
        send_word(CMD_NEXT, '0);
        send_get(-16'sd32768, -16'sd32768);
        send_get(16'sd32767, 16'sd32767);
        send_get(-16'sd32768, 16'sd32767);
        send_get(16'sd32767, -16'sd32768);
        send_get(16'sd0, 16'sd0);
        send_get(-16'sd1, -16'sd1);
        send_get(16'sd32767, 16'sd32767);
        send_get(-16'sd1, -16'sd1);
        send_get(-16'sd32768, -16'sd32768);
        send_word(CMD_START, '0);
        repeat (8)
            send_word(CMD_NEXT, '1);
        send_word(CMD_CLEAR, '1);
        send_word(CMD_NEXT, '0);
        send_get(16'sd5, -16'sd5);
        send_word(CMD_NEXT, '0);
        send_word(CMD_START, '0);
        send_word(CMD_NEXT, '0);

        while (words_sent < WORD_COUNT)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: fill_run();
                4, 5, 6:    iterate_run();
                default:    noise_run();
            endcase
        end
        start <= 1'b0;

        drain = 0;
        while (tracker.awaited.size() != 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (ENTRIES + 8) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
